// ----- hw/rtl/tlbpat_pkg.sv -----
// Shared constants and types for the TLB page table address translator.
package tlbpat_pkg;

  localparam int VA_W        = 16;
  localparam int PA_W        = 15;
  localparam int PAGE_W      = 8;
  localparam int OFFSET_W    = 8;
  localparam int FRAME_W     = 7;
  localparam int NUM_PAGES   = 256;
  localparam int NUM_FRAMES  = 128;
  localparam int TLB_ENTRIES = 16;
  localparam int TLB_IDX_W   = 4;
  localparam int FCNT_W      = 8;

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [OFFSET_W-1:0]  offset_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [TLB_IDX_W-1:0] tlb_idx_t;
  typedef logic [FCNT_W-1:0]    fcnt_t;

  // Result of the two associative TLB searches.
  typedef struct packed {
    logic   hit;
    frame_t frame;
    logic   old_hit;
  } tlb_look_t;

  // TLB write command: a FIFO fill, or a retag of the entry holding the evicted page.
  typedef struct packed {
    logic   en;
    logic   retag;
    frame_t frame;
  } tlb_upd_t;

  // Page table and frame owner write command.
  typedef struct packed {
    logic   en;
    logic   evict;
    page_t  old_page;
    frame_t frame;
  } pt_upd_t;

  // Registered page table read.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } pt_rd_t;

endpackage

// ----- hw/rtl/tlbpat_va_if.sv -----
// Input channel carrying one virtual address per transfer.
interface tlbpat_va_if;
  logic                       valid;
  logic                       ready;
  logic [tlbpat_pkg::VA_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

// ----- hw/rtl/tlbpat_xlat_if.sv -----
// Output channel carrying one translation result per transfer.
interface tlbpat_xlat_if;
  logic                         valid;
  logic                         ready;
  logic [tlbpat_pkg::PA_W-1:0]   physical_address;
  logic                         tlb_hit;
  logic                         page_fault;
  logic                         evicted_valid;
  logic [tlbpat_pkg::PAGE_W-1:0] evicted_page;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output evicted_valid, output evicted_page,
                  input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input page_fault, input evicted_valid, input evicted_page,
                output ready);
endinterface

// ----- hw/rtl/tlbpat_tlb.sv -----
// Fully associative TLB with FIFO fill and in-place retag on eviction.
module tlbpat_tlb (
  input  logic                  clk,
  input  logic                  rst,
  input  tlbpat_pkg::page_t     page,
  input  tlbpat_pkg::page_t     old_page,
  output tlbpat_pkg::tlb_look_t look,
  input  tlbpat_pkg::tlb_upd_t  upd
);
  import tlbpat_pkg::*;

  page_t    tag [TLB_ENTRIES];
  frame_t   frm [TLB_ENTRIES];
  logic     tag_valid [TLB_ENTRIES];
  tlb_idx_t fill_ptr;

  tlb_idx_t hit_idx;
  tlb_idx_t old_idx;
  logic     hit;
  logic     old_hit;

  // The lowest matching entry wins, so scan from the top down.
  always_comb begin
    hit     = 1'b0;
    old_hit = 1'b0;
    hit_idx = '0;
    old_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tag_valid[i] && tag[i] == page) begin
        hit     = 1'b1;
        hit_idx = TLB_IDX_W'(i);
      end
      if (tag_valid[i] && tag[i] == old_page) begin
        old_hit = 1'b1;
        old_idx = TLB_IDX_W'(i);
      end
    end
  end

  assign look.hit     = hit;
  assign look.frame   = frm[hit_idx];
  assign look.old_hit = old_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_ptr <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tag_valid[i] <= 1'b0;
      end
    end else if (upd.en) begin
      if (upd.retag) begin
        tag[old_idx] <= page;
        frm[old_idx] <= upd.frame;
      end else begin
        tag[fill_ptr]       <= page;
        frm[fill_ptr]       <= upd.frame;
        tag_valid[fill_ptr] <= 1'b1;
        fill_ptr            <= fill_ptr + 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tlbpat_ptable.sv -----
// Page table memory with per-page valid bits, and the frame owner memory.
module tlbpat_ptable (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  tlbpat_pkg::page_t   rd_page,
  input  tlbpat_pkg::frame_t  owner_rd_frame,
  output tlbpat_pkg::pt_rd_t  pt_rd,
  output tlbpat_pkg::page_t   owner_rdata,
  input  tlbpat_pkg::page_t   wr_page,
  input  tlbpat_pkg::pt_upd_t upd
);
  import tlbpat_pkg::*;

  frame_t pt_mem    [NUM_PAGES];
  page_t  owner_mem [NUM_FRAMES];
  logic   pt_valid  [NUM_PAGES];
  frame_t rd_frame;
  logic   rd_valid;

  assign pt_rd.valid = rd_valid;
  assign pt_rd.frame = rd_frame;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_frame    <= pt_mem[rd_page];
      owner_rdata <= owner_mem[owner_rd_frame];
    end
    if (upd.en) begin
      pt_mem[wr_page]      <= upd.frame;
      owner_mem[upd.frame] <= wr_page;
    end
  end

  // Valid bits clear at once on reset; the data memories need no clearing.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      for (int i = 0; i < NUM_PAGES; i++) begin
        pt_valid[i] <= 1'b0;
      end
    end else begin
      if (rd_en) begin
        rd_valid <= pt_valid[rd_page];
      end
      if (upd.en) begin
        if (upd.evict) begin
          pt_valid[upd.old_page] <= 1'b0;
        end
        pt_valid[wr_page] <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tlb_page_table_address_translator_unit.sv -----
// Top level of the TLB page table address translator.
//
// Usage: each transfer on va carries a 16-bit virtual address (page in the
// upper 8 bits, offset in the lower 8). Each accepted address produces exactly
// one transfer on xlat with the 15-bit physical address and the TLB hit, page
// fault and eviction flags. Frames are handed out in order until all 128 are
// used, then taken back oldest first; the page that lost its frame is reported.
// Accepting an address registers it and reads the page table and frame owner
// memories; the lookup step then searches the TLB, writes the page table, owner
// memory and TLB back in one step and loads the result into the output register.
// A new address is taken only once the last one has left its lookup step.
// Reset clears all page table and TLB valid bits, the TLB fill pointer and
// the frame counters at once; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register while one
// more address is taken; that address then holds in its lookup cycle until the
// output register is free.
module tlb_page_table_address_translator_unit (
  input logic          clk,
  input logic          rst,
  tlbpat_va_if.sink    va,
  tlbpat_xlat_if.source xlat
);
  import tlbpat_pkg::*;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t  state;
  page_t   page_q;
  offset_t offset_q;
  fcnt_t   frames_in_use;
  frame_t  victim_ptr;

  logic     accept;
  logic     go;
  logic     full;
  frame_t   frame;
  logic     fault;
  logic     use_tlb;
  tlb_look_t look;
  tlb_upd_t tlb_upd;
  pt_upd_t  pt_upd;
  pt_rd_t   pt_rd;
  page_t    owner_rdata;
  page_t    in_page;
  logic [31:0] pa_wide;

  assign va.ready = (state == S_IDLE) && !rst;
  assign accept   = va.valid && va.ready;
  assign in_page  = va.virtual_address[VA_W-1 -: PAGE_W];
  assign go       = (state == S_LOOK) && (!xlat.valid || xlat.ready);
  assign full     = (frames_in_use == fcnt_t'(NUM_FRAMES));

  tlbpat_ptable u_ptable (
    .clk            (clk),
    .rst            (rst),
    .rd_en          (accept),
    .rd_page        (in_page),
    .owner_rd_frame (victim_ptr),
    .pt_rd          (pt_rd),
    .owner_rdata    (owner_rdata),
    .wr_page        (page_q),
    .upd            (pt_upd)
  );

  tlbpat_tlb u_tlb (
    .clk      (clk),
    .rst      (rst),
    .page     (page_q),
    .old_page (owner_rdata),
    .look     (look),
    .upd      (tlb_upd)
  );

  always_comb begin
    use_tlb = look.hit;
    fault   = !look.hit && !pt_rd.valid;
    priority if (look.hit) begin
      frame = look.frame;
    end else if (pt_rd.valid) begin
      frame = pt_rd.frame;
    end else if (full) begin
      frame = victim_ptr;
    end else begin
      frame = frames_in_use[FRAME_W-1:0];
    end

    pt_upd.en       = go && fault;
    pt_upd.evict    = full;
    pt_upd.old_page = owner_rdata;
    pt_upd.frame    = frame;

    tlb_upd.en    = go && !use_tlb;
    tlb_upd.retag = fault && full && look.old_hit;
    tlb_upd.frame = frame;

    pa_wide = (32'(frame) << OFFSET_W) | 32'(offset_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= '0;
      victim_ptr    <= '0;
      xlat.valid    <= 1'b0;
    end else begin
      // A new result loaded in the same cycle keeps the output valid.
      if (xlat.valid && xlat.ready && !go) begin
        xlat.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            page_q   <= in_page;
            offset_q <= va.virtual_address[OFFSET_W-1:0];
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (go) begin
            xlat.valid            <= 1'b1;
            xlat.physical_address <= pa_wide[PA_W-1:0];
            xlat.tlb_hit          <= look.hit;
            xlat.page_fault       <= fault;
            xlat.evicted_valid    <= fault && full;
            xlat.evicted_page     <= (fault && full) ? owner_rdata : '0;
            if (fault) begin
              if (full) begin
                victim_ptr <= (victim_ptr == frame_t'(NUM_FRAMES - 1)) ? '0
                              : victim_ptr + 1'b1;
              end else begin
                frames_in_use <= frames_in_use + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/tlbpat_checker.sv -----
// Port-level checks for the translator, bound to the top level.
module tlbpat_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     va_valid,
  input logic                     va_ready,
  input logic                     xlat_valid,
  input logic                     xlat_ready,
  input logic                     tlb_hit,
  input logic                     page_fault,
  input logic                     evicted_valid,
  input logic [tlbpat_pkg::PAGE_W-1:0] evicted_page
);
  import tlbpat_pkg::*;

  // A stalled result must stay offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    xlat_valid && !xlat_ready |=> xlat_valid)
    else $error("result dropped while stalled");

  // One address is worked on at a time: no transfer directly after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    va_valid && va_ready |=> !va_ready)
    else $error("address taken while another is in its lookup cycle");

  // An eviction only happens on a page fault.
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    xlat_valid && evicted_valid |-> page_fault)
    else $error("eviction reported without a fault");

  // A TLB hit never faults.
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    xlat_valid && tlb_hit |-> !page_fault)
    else $error("fault reported on a TLB hit");

  // The evicted page reads zero when nothing was evicted.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    xlat_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind tlb_page_table_address_translator_unit tlbpat_checker u_tlbpat_checker (
  .clk           (clk),
  .rst           (rst),
  .va_valid      (va.valid),
  .va_ready      (va.ready),
  .xlat_valid    (xlat.valid),
  .xlat_ready    (xlat.ready),
  .tlb_hit       (xlat.tlb_hit),
  .page_fault    (xlat.page_fault),
  .evicted_valid (xlat.evicted_valid),
  .evicted_page  (xlat.evicted_page)
);
